>>> hdl/siul_pkg.sv
package siul_pkg;

	localparam int MAX_SPANS  = 128;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS   = $clog2(MAX_SPANS);
	localparam int CNT_BITS   = $clog2(MAX_SPANS + 1);
	localparam int OP_BITS    = 2;

	localparam int GRP_SIZE = 16;
	localparam int NUM_GRPS = (MAX_SPANS + GRP_SIZE - 1) / GRP_SIZE;

	localparam int IN_BITS       = 2 * COORD_BITS + IDX_BITS;
	localparam int IN_DATA_BITS  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS      = CNT_BITS + 2 * COORD_BITS;
	localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] right;
		logic                  ge;
		logic                  gt;
	} span_cell_t;

	typedef struct packed {
		logic                  classify;
		logic                  merge;
		logic                  stretch;
		logic                  insert;
		logic [CNT_BITS-1:0]   count;
		logic [COORD_BITS-1:0] lo;
		logic [COORD_BITS-1:0] hi;
	} cell_ctrl_t;

	localparam span_cell_t EDGE_HEAD = '{left: '0, right: '0, ge: 1'b0, gt: 1'b0};
	localparam span_cell_t EDGE_TAIL = '{left: '0, right: '0, ge: 1'b1, gt: 1'b1};

endpackage

>>> hdl/siul_cell.sv
module siul_cell
	import siul_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctrl_t          ctrl,
	input  logic [IDX_BITS-1:0] pos,
	input  span_cell_t          prev,
	input  span_cell_t          next,
	output span_cell_t          cur
);

	logic [COORD_BITS-1:0] left_q, right_q, left_d, right_d;
	logic                  ge_q, gt_q, ge_d, gt_d;
	logic                  valid, first_me, ov;

	assign valid    = CNT_BITS'(pos) < ctrl.count;
	assign first_me = ge_q && !prev.ge;
	assign ov       = ge_q && !gt_q;

	always_comb begin
		left_d  = left_q;
		right_d = right_q;
		ge_d    = ge_q;
		gt_d    = gt_q;
		if (ctrl.classify) begin
			ge_d = !valid || (right_q >= ctrl.lo);
			gt_d = !valid || (left_q > ctrl.hi);
		end else if (ctrl.merge) begin
			if (first_me) begin
				right_d = next.right;
			end else if (prev.ge) begin
				left_d  = next.left;
				right_d = next.right;
				ge_d    = next.ge;
				gt_d    = next.gt;
			end
		end else if (ctrl.stretch) begin
			if (ov) begin
				left_d  = (left_q < ctrl.lo) ? left_q : ctrl.lo;
				right_d = (right_q > ctrl.hi) ? right_q : ctrl.hi;
			end
		end else if (ctrl.insert) begin
			if (first_me) begin
				left_d  = ctrl.lo;
				right_d = ctrl.hi;
			end else if (prev.ge) begin
				left_d  = prev.left;
				right_d = prev.right;
				ge_d    = prev.ge;
				gt_d    = prev.gt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q <= 1'b1;
			gt_q <= 1'b1;
		end else begin
			ge_q <= ge_d;
			gt_q <= gt_d;
		end
	end

	always_ff @(posedge clk) begin
		left_q  <= left_d;
		right_q <= right_d;
	end

	assign cur = '{left: left_q, right: right_q, ge: ge_q, gt: gt_q};

endmodule

>>> hdl/siul_read_tree.sv
module siul_read_tree
	import siul_pkg::*;
(
	input  logic                  clk,
	input  logic                  load,
	input  logic [IDX_BITS-1:0]   idx,
	input  span_cell_t            cells [MAX_SPANS],
	output logic [COORD_BITS-1:0] rd_left,
	output logic [COORD_BITS-1:0] rd_right
);

	logic [COORD_BITS-1:0] grp_left_q  [NUM_GRPS];
	logic [COORD_BITS-1:0] grp_right_q [NUM_GRPS];
	logic [COORD_BITS-1:0] grp_left_d  [NUM_GRPS];
	logic [COORD_BITS-1:0] grp_right_d [NUM_GRPS];

	always_comb begin
		int n;
		for (int g = 0; g < NUM_GRPS; g++) begin
			grp_left_d[g]  = '0;
			grp_right_d[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				n = g * GRP_SIZE + k;
				if (n < MAX_SPANS) begin
					if (idx == IDX_BITS'(n)) begin
						grp_left_d[g]  = grp_left_d[g] | cells[n].left;
						grp_right_d[g] = grp_right_d[g] | cells[n].right;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_left_q  <= grp_left_d;
			grp_right_q <= grp_right_d;
		end
	end

	always_comb begin
		rd_left  = '0;
		rd_right = '0;
		for (int g = 0; g < NUM_GRPS; g++) begin
			rd_left  = rd_left | grp_left_q[g];
			rd_right = rd_right | grp_right_q[g];
		end
	end

endmodule

>>> hdl/span_interval_union_list.sv
// Sorted list of disjoint closed spans on one scanline, held in a row of span cells.
// Input stream s_*: one beat is one item; s_tuser carries the operation
// (add, clear, read), s_tdata carries span_low, span_high and read_index.
// Output stream m_*: exactly one beat per item, in item order, with the span
// count after the item, the span read, and the index_valid and overflow flags.
// The item is taken, classified in all cells at once, then merged with one
// merge step for each extra stored span an add absorbs, and the update is
// made as the result beat is loaded into the output register; a new item is
// taken only when the list is idle again, once that result beat is loaded.
// Each cell hands its span one place left per merge step.
// Reset empties the list; stored span values are left as they are.
// A stalled output beat holds in the output register; the next item is still
// taken and worked, and its update waits until the held beat is taken.
module span_interval_union_list
	import siul_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// span_low, span_high, read_index, zero fill
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// operation
	input  logic [OP_BITS-1:0]       s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// span_count, entry_low, entry_high, zero fill
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// index_valid, overflow
	output logic [1:0]               m_tuser
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLASS = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0]            state_q, state_d;
	logic [OP_BITS-1:0]    op_q;
	logic [COORD_BITS-1:0] lo_q, hi_q;
	logic [IDX_BITS-1:0]   idx_q;
	logic [CNT_BITS-1:0]   count_q, count_d;

	logic                  out_valid_q;
	logic [CNT_BITS-1:0]   out_count_q;
	logic [COORD_BITS-1:0] out_left_q, out_right_q;
	logic                  out_ivalid_q, out_ovf_q;

	logic                  out_free, out_load;
	logic [COORD_BITS-1:0] res_left, res_right;
	logic                  res_ivalid, res_ovf;

	cell_ctrl_t            ctrl;
	span_cell_t            cells [MAX_SPANS];
	logic [MAX_SPANS-1:0]  ov;
	logic                  any_ov, any_pair;
	logic [COORD_BITS-1:0] rd_left, rd_right;
	logic                  rd_hit;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	genvar i;
	generate
		for (i = 0; i < MAX_SPANS; i++) begin : g_cell
			span_cell_t prev_c, next_c;
			if (i == 0) begin : g_head
				assign prev_c = EDGE_HEAD;
			end else begin : g_mid_p
				assign prev_c = cells[i-1];
			end
			if (i == MAX_SPANS - 1) begin : g_tail
				assign next_c = EDGE_TAIL;
			end else begin : g_mid_n
				assign next_c = cells[i+1];
			end
			siul_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.pos    (IDX_BITS'(i)),
				.prev   (prev_c),
				.next   (next_c),
				.cur    (cells[i])
			);
			assign ov[i] = cells[i].ge && !cells[i].gt;
		end
	endgenerate

	always_comb begin
		any_ov   = 1'b0;
		any_pair = 1'b0;
		for (int n = 0; n < MAX_SPANS; n++) begin
			any_ov = any_ov | ov[n];
			if (n < MAX_SPANS - 1) begin
				any_pair = any_pair | (ov[n] && ov[n+1]);
			end
		end
	end

	siul_read_tree u_read (
		.clk      (clk),
		.load     (state_q == ST_CLASS),
		.idx      (idx_q),
		.cells    (cells),
		.rd_left  (rd_left),
		.rd_right (rd_right)
	);

	assign rd_hit = CNT_BITS'(idx_q) < count_q;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		ctrl.classify = 1'b0;
		ctrl.merge    = 1'b0;
		ctrl.stretch  = 1'b0;
		ctrl.insert   = 1'b0;
		ctrl.count    = count_q;
		ctrl.lo       = lo_q;
		ctrl.hi       = hi_q;
		out_load      = 1'b0;
		res_left      = '0;
		res_right     = '0;
		res_ivalid    = 1'b0;
		res_ovf       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_CLASS;
				end
			end
			ST_CLASS: begin
				ctrl.classify = 1'b1;
				if (op_q == OP_ADD && lo_q <= hi_q) begin
					state_d = ST_MERGE;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_MERGE: begin
				if (any_pair) begin
					ctrl.merge = 1'b1;
					count_d    = count_q - 1'b1;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (any_ov) begin
						ctrl.stretch = 1'b1;
					end else if (count_q < CNT_BITS'(MAX_SPANS)) begin
						ctrl.insert = 1'b1;
						count_d     = count_q + 1'b1;
					end else begin
						res_ovf = 1'b1;
					end
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					case (op_q)
						OP_ADD: begin
							res_ovf = 1'b1;
						end
						OP_CLEAR: begin
							count_d = '0;
						end
						OP_READ: begin
							if (rd_hit) begin
								res_ivalid = 1'b1;
								res_left   = rd_left;
								res_right  = rd_right;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser;
			lo_q  <= s_tdata[COORD_BITS-1:0];
			hi_q  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			idx_q <= s_tdata[IN_BITS-1:2*COORD_BITS];
		end
		if (out_load) begin
			out_count_q  <= count_d;
			out_left_q   <= res_left;
			out_right_q  <= res_right;
			out_ivalid_q <= res_ivalid;
			out_ovf_q    <= res_ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'({out_right_q, out_left_q, out_count_q});
	assign m_tuser  = {out_ovf_q, out_ivalid_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_SPANS))
		else $error("span count above capacity");

	a_merge_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && any_pair) |=> count_q == CNT_BITS'($past(count_q) - 1'b1))
		else $error("merge step did not drop one span");

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("read hit and dropped add on one beat");

	a_pair_has_ov: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && any_pair) |=> any_ov)
		else $error("overlap region lost during merge");

endmodule
